// File: rtl/mvrq_pkg.sv
// Shared constants, the queue entry type and the slice computation of the ready queue.
package mvrq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
	localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int VRUN_W      = 63;
	localparam int ID_W        = 8;
	localparam int PRIO_W      = 8;
	localparam int LIVE_W      = 7;
	localparam int SLICE_W     = 4;
	localparam int SLEFT_W     = 8;
	localparam int ENTRY_W     = VRUN_W + ID_W + PRIO_W;
	localparam int LIVE_MAX    = 127;
	localparam int IN_DATA_W   = 88;
	localparam int OUT_DATA_W  = 24;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 64;

	localparam logic MODE_ENQUEUE  = 1'b0;
	localparam logic MODE_SCHEDULE = 1'b1;

	typedef struct packed {
		logic [VRUN_W-1:0] vrun;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// New slice: 4 divided by the live count (zero counts as one), tripled for priority 2 and up.
	function automatic logic [SLICE_W-1:0] slice_calc(logic [LIVE_W-1:0] live,
		logic [PRIO_W-1:0] prio);
		logic [SLICE_W-1:0] base;
		if (live <= LIVE_W'(1)) begin
			base = SLICE_W'(4);
		end else if (live == LIVE_W'(2)) begin
			base = SLICE_W'(2);
		end else if (live <= LIVE_W'(4)) begin
			base = SLICE_W'(1);
		end else begin
			base = '0;
		end
		if (prio >= PRIO_W'(2)) begin
			return SLICE_W'(base * SLICE_W'(3));
		end
		return base;
	endfunction

endpackage

// File: rtl/mvrq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mvrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/min_vruntime_ready_queue_scheduler.sv
// Ready queue sorted by virtual run time, held as a ring in one RAM, with schedule decisions.
//
//  channel   direction  signals                         content
//  s_        in         s_tvalid s_tready s_tdata       tdata: task_id, task_vrun, task_priority,
//                       s_tuser                         cur_runnable, slice_left; tuser: mode
//  m_        out        m_tvalid m_tready m_tdata       run_task, switched, slice_new, slice_set,
//                                                       queue_full, live_count
//  apb       in/out     psel penable pwrite paddr ...   idle_vrun at 0x0, idle_priority at 0x8
//
// One item at a time. In an enqueue each entry found not below the new time is read from
// the RAM and then written one slot up to make room, and the new entry goes into the free
// slot. A dropped or idle enqueue goes straight to the output state. A schedule item
// reads the head when the queue is not empty and, when the current task is requeued, inserts
// it the same way. The queue is a ring with a head pointer, so a pop costs a single RAM read.
// No clearing pass after reset: only entries below the queue length are ever read.
// s_tready is low from the transfer until the result has been loaded into the output register.
module min_vruntime_ready_queue_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [7:0] task_id, [70:8] task_vrun, [78:71] task_priority, [79] cur_runnable,
	// [87:80] slice_left
	input  logic [mvrq_pkg::IN_DATA_W-1:0] s_tdata,
	// [0] mode
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] run_task, [8] switched, [12:9] slice_new, [13] slice_set, [14] queue_full,
	// [21:15] live_count, [23:22] zero
	output logic [mvrq_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mvrq_pkg::PADDR_W-1:0]   paddr,
	input  logic [mvrq_pkg::PDATA_W-1:0]   pwdata,
	output logic [mvrq_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import mvrq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_INS_RD,
		ST_INS_CMP,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   head_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    p_q;
	logic [LIVE_W-1:0]   live_q;
	logic                mode_q;
	logic                runnable_q;
	logic                slice0_q;
	entry_t              new_q;
	logic [PRIO_W-1:0]   n_prio_q;
	logic [ID_W-1:0]     run_task_q;
	logic                switched_q;
	logic                full_q;
	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [VRUN_W-1:0]   idle_vrun_q;
	logic [PRIO_W-1:0]   idle_prio_q;

	logic                in_xfer;
	logic                cfg_wr;
	logic                in_mode;
	entry_t              in_entry;
	logic                in_runnable;
	logic [SLEFT_W-1:0]  in_slice_left;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ADDR_W-1:0]   ram_raddr;
	entry_t              ram_wdata;
	entry_t              ram_rdata;
	logic                slice_set;
	logic [SLICE_W-1:0]  slice_new;

	function automatic logic [ADDR_W-1:0] phys(logic [ADDR_W-1:0] h, logic [LEN_W-1:0] p);
		logic [ADDR_W:0] s;
		s = {1'b0, h} + (ADDR_W+1)'(p);
		if (s >= (ADDR_W+1)'(QUEUE_DEPTH)) begin
			s = s - (ADDR_W+1)'(QUEUE_DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

	assign s_tready      = (state_q == ST_IDLE);
	assign in_xfer       = s_tvalid && s_tready;
	assign in_mode       = s_tuser;
	assign in_entry.id   = s_tdata[7:0];
	assign in_entry.vrun = s_tdata[70:8];
	assign in_entry.prio = s_tdata[78:71];
	assign in_runnable   = s_tdata[79];
	assign in_slice_left = s_tdata[87:80];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[3] ? PDATA_W'(idle_prio_q) : PDATA_W'(idle_vrun_q);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	mvrq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// In the insertion loop an entry found not below the new time moves up by one slot.
	always_comb begin
		ram_raddr = head_q;
		ram_we    = 1'b0;
		ram_waddr = phys(head_q, p_q);
		ram_wdata = new_q;
		unique case (state_q)
			ST_INS_RD: begin
				if (p_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = phys(head_q, p_q - LEN_W'(1));
				end
			end
			ST_INS_CMP: begin
				ram_we = 1'b1;
				if (ram_rdata.vrun >= new_q.vrun) begin
					ram_wdata = ram_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	assign slice_set = (mode_q == MODE_SCHEDULE) && slice0_q;
	assign slice_new = slice_set ? slice_calc(live_q, n_prio_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			len_q       <= '0;
			p_q         <= '0;
			live_q      <= LIVE_W'(1);
			mode_q      <= MODE_ENQUEUE;
			runnable_q  <= 1'b0;
			slice0_q    <= 1'b0;
			new_q       <= '0;
			n_prio_q    <= '0;
			run_task_q  <= '0;
			switched_q  <= 1'b0;
			full_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			idle_vrun_q <= '0;
			idle_prio_q <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[3]) begin
					idle_prio_q <= pwdata[PRIO_W-1:0];
				end else begin
					idle_vrun_q <= pwdata[VRUN_W-1:0];
				end
			end
			// In ST_OUT the output register is handled below.
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						mode_q     <= in_mode;
						runnable_q <= in_runnable;
						slice0_q   <= (in_slice_left == '0);
						new_q      <= in_entry;
						n_prio_q   <= idle_prio_q;
						run_task_q <= '0;
						switched_q <= 1'b0;
						full_q     <= 1'b0;
						p_q        <= len_q;
						if (in_mode == MODE_ENQUEUE) begin
							if (in_entry.id == '0) begin
								state_q <= ST_OUT;
							end else if (len_q == LEN_W'(QUEUE_DEPTH)) begin
								full_q  <= 1'b1;
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_INS_RD;
							end
						end else if (len_q != '0) begin
							state_q <= ST_POP;
						end else if (in_entry.vrun >= idle_vrun_q) begin
							// Empty queue: switch to idle and requeue the current task when it is runnable and not idle.
							switched_q <= 1'b1;
							if (in_runnable && in_entry.id != '0) begin
								state_q <= ST_INS_RD;
							end else begin
								state_q <= ST_OUT;
							end
						end else begin
							run_task_q <= in_entry.id;
							state_q    <= ST_OUT;
						end
					end
				end
				ST_POP: begin
					n_prio_q <= ram_rdata.prio;
					if (new_q.vrun >= ram_rdata.vrun) begin
						run_task_q <= ram_rdata.id;
						switched_q <= 1'b1;
						head_q     <= phys(head_q, LEN_W'(1));
						len_q      <= len_q - LEN_W'(1);
						p_q        <= len_q - LEN_W'(1);
						if (live_q != '0) begin
							live_q <= live_q - LIVE_W'(1);
						end
						if (runnable_q && new_q.id != '0) begin
							state_q <= ST_INS_RD;
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						// The popped minimum goes straight back to the head; the count
						// only changes when it had fallen to zero.
						run_task_q <= new_q.id;
						if (live_q == '0) begin
							live_q <= LIVE_W'(1);
						end
						state_q <= ST_OUT;
					end
				end
				ST_INS_RD: begin
					if (p_q == '0) begin
						len_q <= len_q + LEN_W'(1);
						if (live_q != LIVE_W'(LIVE_MAX)) begin
							live_q <= live_q + LIVE_W'(1);
						end
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (ram_rdata.vrun >= new_q.vrun) begin
						p_q     <= p_q - LEN_W'(1);
						state_q <= ST_INS_RD;
					end else begin
						len_q <= len_q + LEN_W'(1);
						if (live_q != LIVE_W'(LIVE_MAX)) begin
							live_q <= live_q + LIVE_W'(1);
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, live_q, full_q, slice_set, slice_new,
							switched_q, run_task_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(QUEUE_DEPTH))
		else $error("queue length beyond depth");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("input taken while an item is in work");

	a_full_only_enq: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> !m_tdata[8] && !m_tdata[13])
		else $error("queue full flagged on a schedule result");

	a_slice_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[12:9] != '0) |-> m_tdata[13])
		else $error("slice value without slice set");

endmodule
